[rtl/deq_pkg.sv]
package deq_pkg;

  localparam int CMD_W    = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } ctrl_t;

endpackage

[rtl/deq_req_if.sv]
interface deq_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [deq_pkg::CMD_W-1:0]             command;
  logic signed [deq_pkg::DATA_W-1:0]     push_value;

  modport source (output valid, command, push_value, input ready);
  modport sink   (input valid, command, push_value, output ready);
endinterface

[rtl/deq_rsp_if.sv]
interface deq_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [deq_pkg::DATA_W-1:0]     popped_value;
  logic [deq_pkg::STATUS_W-1:0]          status;
  logic [deq_pkg::OCC_W-1:0]             occupancy;

  modport source (output valid, popped_value, status, occupancy, input ready);
  modport sink   (input valid, popped_value, status, occupancy, output ready);
endinterface

[rtl/double_ended_queue_core.sv]
// Channel  Dir  Fields                                    Handshake
// req      in   command[1:0], push_value[31:0] signed     valid / ready
// rsp      out  popped_value[31:0] signed, status[1:0],   valid / ready
//               occupancy[4:0]
//
// One command at a time: three steps from accept to result (capture,
// execute on the ring RAM, load result); the RAM's registered read sets them.
// req.ready is high in the idle state, also while a result still waits.
// A stalled rsp holds the word; a finished command waits for it to drain.
// Synchronous reset empties the queue (pointers and count); RAM keeps data.
module double_ended_queue_core #(
  parameter int DEPTH = 16
) (
  input logic       clk,
  input logic       rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);

  deq_pkg::ctrl_t ctrl;
  logic           res_free;

  // Sequencer: idle -> execute -> done; done waits on the result register.
  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .res_free (res_free),
    .in_ready (req.ready),
    .ctrl     (ctrl)
  );

  // Ring buffer: front and back pointers, count, word RAM, result register.
  deq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .command      (req.command),
    .push_value   (req.push_value),
    .out_ready    (rsp.ready),
    .res_free     (res_free),
    .out_valid    (rsp.valid),
    .popped_value (rsp.popped_value),
    .status       (rsp.status),
    .occupancy    (rsp.occupancy)
  );

endmodule

[rtl/deq_ram.sv]
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/deq_ctrl.sv]
module deq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           res_free,
  output logic           in_ready,
  output deq_pkg::ctrl_t ctrl
);

  deq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= deq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    ctrl.capture = 1'b0;
    ctrl.exec    = 1'b0;
    ctrl.load    = 1'b0;
    case (state)
      deq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.capture = 1'b1;
          state_next   = deq_pkg::ST_EXEC;
        end
      end
      deq_pkg::ST_EXEC: begin
        ctrl.exec  = 1'b1;
        state_next = deq_pkg::ST_DONE;
      end
      deq_pkg::ST_DONE: begin
        // hold until the result register can take the word
        if (res_free) begin
          ctrl.load  = 1'b1;
          state_next = deq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = deq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/deq_dpath.sv]
module deq_dpath #(
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  deq_pkg::ctrl_t                         ctrl,
  input  logic [deq_pkg::CMD_W-1:0]              command,
  input  logic signed [deq_pkg::DATA_W-1:0]      push_value,
  input  logic                                   out_ready,
  output logic                                   res_free,
  output logic                                   out_valid,
  output logic signed [deq_pkg::DATA_W-1:0]      popped_value,
  output logic [deq_pkg::STATUS_W-1:0]           status,
  output logic [deq_pkg::OCC_W-1:0]              occupancy
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [deq_pkg::CMD_W-1:0]    cmd_q;
  logic [deq_pkg::DATA_W-1:0]   value_q;
  logic [AW-1:0]                front, front_next;
  logic [AW-1:0]                back, back_next;
  logic [CW-1:0]                count, count_next;
  logic [deq_pkg::STATUS_W-1:0] status_q, status_next;
  logic                         pop_ok_q, pop_ok_next;

  logic [AW-1:0] front_inc, front_dec, back_inc, back_dec;
  logic          is_full, is_empty;

  logic                         wr_en, rd_en;
  logic [AW-1:0]                wr_addr, rd_addr;
  logic [deq_pkg::DATA_W-1:0]   rd_data;

  assign front_inc = (front == LAST) ? '0 : front + 1'b1;
  assign front_dec = (front == '0) ? LAST : front - 1'b1;
  assign back_inc  = (back == LAST) ? '0 : back + 1'b1;
  assign back_dec  = (back == '0) ? LAST : back - 1'b1;
  assign is_full   = (count == CW'(DEPTH));
  assign is_empty  = (count == '0);

  always_comb begin
    front_next  = front;
    back_next   = back;
    count_next  = count;
    status_next = deq_pkg::STATUS_OK;
    pop_ok_next = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    wr_addr     = back;
    rd_addr     = front;
    case (cmd_q)
      deq_pkg::CMD_PUSH_FRONT: begin
        if (is_full) begin
          status_next = deq_pkg::STATUS_FULL;
        end else begin
          wr_en      = ctrl.exec;
          wr_addr    = front_dec;
          front_next = front_dec;
          count_next = count + 1'b1;
        end
      end
      deq_pkg::CMD_PUSH_BACK: begin
        if (is_full) begin
          status_next = deq_pkg::STATUS_FULL;
        end else begin
          wr_en      = ctrl.exec;
          back_next  = back_inc;
          count_next = count + 1'b1;
        end
      end
      deq_pkg::CMD_POP_FRONT: begin
        if (is_empty) begin
          status_next = deq_pkg::STATUS_EMPTY;
        end else begin
          rd_en       = ctrl.exec;
          pop_ok_next = 1'b1;
          front_next  = front_inc;
          count_next  = count - 1'b1;
        end
      end
      deq_pkg::CMD_POP_BACK: begin
        if (is_empty) begin
          status_next = deq_pkg::STATUS_EMPTY;
        end else begin
          rd_en       = ctrl.exec;
          rd_addr     = back_dec;
          pop_ok_next = 1'b1;
          back_next   = back_dec;
          count_next  = count - 1'b1;
        end
      end
      default: begin
        status_next = deq_pkg::STATUS_OK;
      end
    endcase
  end

  deq_ram #(
    .WIDTH (deq_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (value_q),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // payload captures
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q   <= command;
      value_q <= push_value;
    end
    if (ctrl.exec) begin
      status_q <= status_next;
      pop_ok_q <= pop_ok_next;
    end
    if (ctrl.load) begin
      popped_value <= pop_ok_q ? rd_data : '0;
      status       <= status_q;
      occupancy    <= deq_pkg::OCC_W'(count);
    end
  end

  // ring state and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      back      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.exec) begin
        front <= front_next;
        back  <= back_next;
        count <= count_next;
      end
      if (ctrl.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign res_free = !out_valid || out_ready;

endmodule

[dv/tb_double_ended_queue_core.sv]
`timescale 1ns / 1ps

module tb_double_ended_queue_core;

  localparam int DEPTH      = 16;
  // Slowest legal run: ~1380 words, each with an idle burst, the full command
  // latency and a response stall. Taken several times over.
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WORDS = 1350;
  localparam int QUIET_TAIL   = 150;   // last words with no idling at all

  // one expected response word
  typedef struct {
    logic signed [deq_pkg::DATA_W-1:0] popped_value;
    logic [deq_pkg::STATUS_W-1:0]      status;
    logic [deq_pkg::OCC_W-1:0]         occupancy;
  } deq_result_t;

  // Shadow deque plus queue of the responses it predicts.
  class deq_scoreboard;
    logic signed [deq_pkg::DATA_W-1:0] ring [DEPTH];
    int          head;
    int          fill;
    deq_result_t awaited[$];
    int          errors;
    int          checked;
    int          n_push;
    int          n_pop;
    int          n_full;
    int          n_empty;

    function new();
      head = 0;
      fill = 0;
      errors = 0;
      checked = 0;
      n_push = 0;
      n_pop = 0;
      n_full = 0;
      n_empty = 0;
    endfunction

    // Apply an accepted command to the shadow deque and queue its response.
    function void note_command(logic [deq_pkg::CMD_W-1:0] cmd,
                               logic signed [deq_pkg::DATA_W-1:0] value);
      deq_result_t r;
      r.popped_value = '0;
      r.status       = deq_pkg::STATUS_OK;
      if (cmd == deq_pkg::CMD_PUSH_FRONT || cmd == deq_pkg::CMD_PUSH_BACK) begin
        if (fill >= DEPTH) begin
          r.status = deq_pkg::STATUS_FULL;
          n_full++;
        end else if (cmd == deq_pkg::CMD_PUSH_FRONT) begin
          head = (head + DEPTH - 1) % DEPTH;
          ring[head] = value;
          fill++;
          n_push++;
        end else begin
          ring[(head + fill) % DEPTH] = value;
          fill++;
          n_push++;
        end
      end else begin
        if (fill == 0) begin
          r.status = deq_pkg::STATUS_EMPTY;
          n_empty++;
        end else if (cmd == deq_pkg::CMD_POP_FRONT) begin
          r.popped_value = ring[head];
          head = (head + 1) % DEPTH;
          fill--;
          n_pop++;
        end else begin
          r.popped_value = ring[(head + fill - 1) % DEPTH];
          fill--;
          n_pop++;
        end
      end
      r.occupancy = fill[deq_pkg::OCC_W-1:0];
      awaited.push_back(r);
    endfunction

    task report_mismatch(string what, logic [deq_pkg::DATA_W-1:0] got,
                         logic [deq_pkg::DATA_W-1:0] want);
      errors++;
      $display("[%0t] MISMATCH %s: got 0x%08h, want 0x%08h", $realtime, what, got, want);
    endtask

    task check_result(logic signed [deq_pkg::DATA_W-1:0] popped_value,
                      logic [deq_pkg::STATUS_W-1:0] status,
                      logic [deq_pkg::OCC_W-1:0] occupancy);
      deq_result_t w;
      if (awaited.size() == 0) begin
        report_mismatch("unexpected response word", popped_value, '0);
      end else begin
        w = awaited.pop_front();
        checked++;
        if (popped_value !== w.popped_value)
          report_mismatch("popped_value", popped_value, w.popped_value);
        if (status !== w.status)
          report_mismatch("status", deq_pkg::DATA_W'(status), deq_pkg::DATA_W'(w.status));
        if (occupancy !== w.occupancy)
          report_mismatch("occupancy", deq_pkg::DATA_W'(occupancy),
                          deq_pkg::DATA_W'(w.occupancy));
      end
    endtask
  endclass

  logic clk;
  logic rst;

  deq_req_if req ();
  deq_rsp_if rsp ();

  double_ended_queue_core #(
    .DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  deq_scoreboard sb = new();

  // idle controls, flipped per segment by the stimulus
  bit src_idle_on;
  bit sink_stall_on;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset once, at the start of the run.
  initial begin
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog: a hung handshake or a lost response ends the run here.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles", cycles);
    $display("Mismatches found");
    $finish;
  end

  // Response side: ready high, with random stall bursts while stalling is on.
  initial begin
    rsp.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (sink_stall_on && $urandom_range(0, 5) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Monitor: values read here are those held at the edge.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      sb.check_result(rsp.popped_value, rsp.status, rsp.occupancy);
  end

  // Present one command word and hold it until it is taken. An idle burst
  // may come first; valid stays high between back-to-back words.
  task automatic send_word(logic [deq_pkg::CMD_W-1:0] cmd,
                           logic signed [deq_pkg::DATA_W-1:0] value);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.command    <= cmd;
    req.push_value <= value;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_command(cmd, value);
  endtask

  // Mostly fully random words, now and then one of the corner values.
  function automatic logic [deq_pkg::DATA_W-1:0] pick_value();
    logic [deq_pkg::DATA_W-1:0] v;
    v = $urandom;
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 3))
        0: v = 32'h8000_0000;
        1: v = 32'h7fff_ffff;
        2: v = 32'h0000_0000;
        default: v = 32'hffff_ffff;
      endcase
    end
    return v;
  endfunction

  initial begin
    int seg_left;
    int push_pct;
    logic [deq_pkg::CMD_W-1:0] cmd;

    req.valid      = 1'b0;
    req.command    = deq_pkg::CMD_PUSH_FRONT;
    req.push_value = '0;
    src_idle_on    = 1'b0;
    sink_stall_on  = 1'b0;

    @(posedge clk);
    while (rst) @(posedge clk);

    // --- directed part ---
    // pops on an empty deque, from both ends
    send_word(deq_pkg::CMD_POP_FRONT, $urandom);
    send_word(deq_pkg::CMD_POP_BACK, $urandom);
    // extremes of the word, front pointer wraps below zero
    send_word(deq_pkg::CMD_PUSH_BACK, 32'h8000_0000);
    send_word(deq_pkg::CMD_PUSH_FRONT, 32'h7fff_ffff);
    send_word(deq_pkg::CMD_POP_FRONT, '0);
    // last word leaves from the back: must empty the deque cleanly
    send_word(deq_pkg::CMD_POP_BACK, '0);
    send_word(deq_pkg::CMD_POP_BACK, '0);
    send_word(deq_pkg::CMD_PUSH_FRONT, 32'hffff_ffff);
    send_word(deq_pkg::CMD_POP_BACK, '0);
    // fill from both ends to the brim, then push on a full deque
    send_word(deq_pkg::CMD_PUSH_FRONT, 32'h0000_0000);
    for (int i = 0; i < DEPTH - 1; i++)
      send_word(i % 2 ? deq_pkg::CMD_PUSH_FRONT : deq_pkg::CMD_PUSH_BACK, $urandom);
    send_word(deq_pkg::CMD_PUSH_FRONT, 32'h1234_5678);
    send_word(deq_pkg::CMD_PUSH_BACK, 32'hdead_beef);

    // --- random part ---
    // Segments lean towards pushing or popping so the deque swings between
    // empty and full; idling is chosen per segment so quiet stretches occur.
    seg_left = 0;
    push_pct = 50;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 60);
        case ($urandom_range(0, 2))
          0: push_pct = 80;
          1: push_pct = 20;
          default: push_pct = 50;
        endcase
        src_idle_on   = $urandom_range(0, 2) != 0;
        sink_stall_on = $urandom_range(0, 2) != 0;
      end
      seg_left--;
      // last stretch runs flat out on both sides
      if (n >= RANDOM_WORDS - QUIET_TAIL) begin
        src_idle_on   = 1'b0;
        sink_stall_on = 1'b0;
      end
      if ($urandom_range(0, 99) < push_pct)
        cmd = $urandom_range(0, 1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT;
      else
        cmd = $urandom_range(0, 1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT;
      send_word(cmd, pick_value());
    end
    req.valid <= 1'b0;

    // drain all awaited responses, then idle before the summary
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d responses: %0d pushes, %0d pops, %0d on full, %0d on empty",
             sb.checked, sb.n_push, sb.n_pop, sb.n_full, sb.n_empty);
    $display("Both ends used, random idle and stall bursts, flat-out tail");
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
